// ----- rtl/framebuffer_pixel_expander_macros.svh -----
// ----------------------------------------------------------------------------
// framebuffer pixel expander assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_PIXEL_EXPANDER_MACROS_SVH
`define FRAMEBUFFER_PIXEL_EXPANDER_MACROS_SVH

// expression must never be true
`define FBPE_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("assertion failed: never");

// consequent must hold in the cycle after the antecedent
`define FBPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next");

`endif

// ----- rtl/fbpe_pkg.sv -----
// ----------------------------------------------------------------------------
// fbpe_pkg
// shared types and constants of the frame-buffer pixel expander
// ----------------------------------------------------------------------------
package fbpe_pkg;

  localparam int IDX_W   = 8;
  localparam int RANGE_W = IDX_W + 1;
  localparam int PIX_W   = 32;
  localparam int RGB_W   = 24;
  localparam int DEPTH_W = 3;

  localparam logic [DEPTH_W-1:0] DEPTH_MONO  = 3'd0;
  localparam logic [DEPTH_W-1:0] DEPTH_PAL2  = 3'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_PAL4  = 3'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_PAL8  = 3'd3;
  localparam logic [DEPTH_W-1:0] DEPTH_RGB16 = 3'd4;
  localparam logic [DEPTH_W-1:0] DEPTH_RGB32 = 3'd5;

  localparam logic CFG_COLOR = 1'b0;
  localparam logic CFG_DEPTH = 1'b1;

  typedef struct packed {
    logic               color_enable;
    logic [DEPTH_W-1:0] pixel_depth;
  } cfg_t;

  typedef struct packed {
    logic             lookup;
    logic             hit;
    logic [IDX_W-1:0] index;
    logic [PIX_W-1:0] direct;
    logic             last;
  } pix_req_t;

endpackage

// ----- rtl/framebuffer_pixel_expander.sv -----
// ----------------------------------------------------------------------------
// framebuffer_pixel_expander
// Expands packed frame-buffer beats into one output pixel beat per cycle while
// the output is not stalled. A monochrome byte gives 8 pixels, palette depths
// of 2, 4 and 8 bits give 4, 2 and 1 pixels, RGB555 and 32-bit words give one
// pixel each, and palette writes give none. An input beat passes through the
// unpack register, the palette ram read and the output register. The palette
// reads as zero after reset through per-entry valid flops, so there is no
// clearing pass and no startup delay.
// ----------------------------------------------------------------------------
`include "framebuffer_pixel_expander_macros.svh"

module framebuffer_pixel_expander
  import fbpe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [DEPTH_W-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               mode_i,
  input  logic [IDX_W-1:0]   palette_index_i,
  input  logic [15:0]        red_level_i,
  input  logic [15:0]        green_level_i,
  input  logic [15:0]        blue_level_i,
  input  logic [PIX_W-1:0]   frame_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PIX_W-1:0]   pixel_value_o,
  output logic               last_pixel_o
);

  localparam int ADDR_W = $clog2(PALETTE_ENTRIES);

  cfg_t                 cfg_q;
  logic                 in_ready;
  logic                 req_valid;
  pix_req_t             req;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [RGB_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [RGB_W-1:0]     ram_rdata;
  logic [PALETTE_ENTRIES-1:0] pal_vld_q;

  logic                 s1_valid_q;
  pix_req_t             s1_req_q;
  logic                 s1_pvld_q;
  logic                 s1_ready;
  logic                 s1_load;
  logic                 s2_valid_q;
  logic [PIX_W-1:0]     s2_pix_q;
  logic                 s2_last_q;
  logic                 s2_ready;
  logic [PIX_W-1:0]     s2_pix_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_enable <= 1'b0;
      cfg_q.pixel_depth  <= DEPTH_PAL8;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR: cfg_q.color_enable <= cfg_wdata_i[0];
        CFG_DEPTH: cfg_q.pixel_depth  <= cfg_wdata_i;
        default:   cfg_q.pixel_depth  <= cfg_q.pixel_depth;
      endcase
    end
  end

  fbpe_unpack #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready),
    .mode_i          (mode_i),
    .palette_index_i (palette_index_i),
    .red_level_i     (red_level_i),
    .green_level_i   (green_level_i),
    .blue_level_i    (blue_level_i),
    .frame_word_i    (frame_word_i),
    .req_valid_o     (req_valid),
    .req_ready_i     (s1_ready),
    .req_o           (req),
    .pal_we_o        (ram_we),
    .pal_waddr_o     (ram_waddr),
    .pal_wdata_o     (ram_wdata)
  );

  assign in_stall_o = !in_ready;

  assign s2_ready  = !s2_valid_q || !out_stall_i;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign s1_load   = req_valid && s1_ready;
  assign ram_re    = s1_load && req.lookup;
  assign ram_raddr = req.index[ADDR_W-1:0];

  fbpe_ram #(
    .WIDTH(RGB_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_vld_q <= '0;
    end else if (ram_we) begin
      pal_vld_q[ram_waddr] <= 1'b1;
    end
  end

  // stage 1: palette read in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= req_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_req_q  <= req;
      s1_pvld_q <= pal_vld_q[ram_raddr];
    end
  end

  // stage 2: output register
  always_comb begin
    if (s1_req_q.lookup) begin
      s2_pix_d = (s1_req_q.hit && s1_pvld_q) ? {ram_rdata, 8'h00} : '0;
    end else begin
      s2_pix_d = s1_req_q.direct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_pix_q  <= s2_pix_d;
      s2_last_q <= s1_req_q.last;
    end
  end

  assign out_valid_o   = s2_valid_q;
  assign pixel_value_o = s2_pix_q;
  assign last_pixel_o  = s2_last_q;

  `FBPE_ASSERT_NEVER(a_pal_rw_excl, ram_we && ram_re)
  `FBPE_ASSERT_NEXT(a_s1_hold, s1_valid_q && !s2_ready, s1_valid_q && $stable(s1_req_q))
  `FBPE_ASSERT_NEXT(a_out_fed, s1_valid_q && s2_ready, s2_valid_q)

endmodule

// ----- rtl/fbpe_ram.sv -----
// ----------------------------------------------------------------------------
// fbpe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fbpe_ram #(
  parameter int WIDTH  = 24,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fbpe_unpack.sv -----
// ----------------------------------------------------------------------------
// fbpe_unpack
// holds one input beat and issues one pixel request per cycle from it unless
// stalled; palette writes are carried out here in order with the lookups
// ----------------------------------------------------------------------------
module fbpe_unpack
  import fbpe_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  localparam int ADDR_W = $clog2(PALETTE_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic [IDX_W-1:0]    palette_index_i,
  input  logic [15:0]         red_level_i,
  input  logic [15:0]         green_level_i,
  input  logic [15:0]         blue_level_i,
  input  logic [PIX_W-1:0]    frame_word_i,
  output logic                req_valid_o,
  input  logic                req_ready_i,
  output pix_req_t            req_o,
  output logic                pal_we_o,
  output logic [ADDR_W-1:0]   pal_waddr_o,
  output logic [RGB_W-1:0]    pal_wdata_o
);

  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_MONO,
    KIND_PAL2,
    KIND_PAL4,
    KIND_PAL8,
    KIND_RGB16,
    KIND_RGB32
  } kind_e;

  localparam logic [RANGE_W-1:0] ENTRIES = RANGE_W'(PALETTE_ENTRIES);

  logic             s0_valid_q, s0_valid_d;
  kind_e            kind_q, kind_d;
  logic [2:0]       pos_q, pos_d;
  logic [PIX_W-1:0] data_q, data_d;

  logic [2:0]       last_pos;
  logic             is_last;
  logic             issue;
  logic             accept;
  kind_e            kind_in;
  logic             keep_in;

  function automatic logic [PIX_W-1:0] rgb555(input logic [15:0] t);
    rgb555 = {t[14:10], t[14:12], t[9:5], t[9:7], t[4:0], t[4:2], 8'h00};
  endfunction

  always_comb begin
    unique case (kind_q)
      KIND_MONO: last_pos = 3'd7;
      KIND_PAL2: last_pos = 3'd3;
      KIND_PAL4: last_pos = 3'd1;
      default:   last_pos = 3'd0;
    endcase
  end

  assign is_last    = (pos_q == last_pos);
  assign issue      = s0_valid_q && ((kind_q == KIND_WRITE) || req_ready_i);
  assign in_ready_o = !s0_valid_q || (issue && is_last);
  assign accept     = in_valid_i && in_ready_o;

  // pixel request from the current beat
  always_comb begin
    req_o = '0;
    req_o.last = is_last;
    unique case (kind_q)
      KIND_PAL2: begin
        req_o.lookup = 1'b1;
        req_o.index  = {6'b0, data_q[7:6]};
      end
      KIND_PAL4: begin
        req_o.lookup = 1'b1;
        req_o.index  = {4'b0, data_q[7:4]};
      end
      KIND_PAL8: begin
        req_o.lookup = 1'b1;
        req_o.index  = data_q[7:0];
      end
      KIND_MONO: begin
        req_o.direct = data_q[7] ? 32'h0000_0000 : 32'h0000_00FF;
      end
      KIND_RGB16: begin
        req_o.direct = rgb555(data_q[15:0]);
      end
      KIND_RGB32: begin
        req_o.direct = {data_q[23:0], 8'h00};
      end
      default: begin
        req_o.index = data_q[7:0];
      end
    endcase
    req_o.hit = ({1'b0, req_o.index} < ENTRIES);
  end

  assign req_valid_o = s0_valid_q && (kind_q != KIND_WRITE);
  assign pal_we_o    = s0_valid_q && (kind_q == KIND_WRITE) && req_o.hit;
  assign pal_waddr_o = data_q[ADDR_W-1:0];
  assign pal_wdata_o = data_q[31:8];

  // classify an incoming beat
  always_comb begin
    keep_in = 1'b1;
    kind_in = KIND_WRITE;
    if (mode_i) begin
      if (!cfg_i.color_enable) begin
        kind_in = KIND_MONO;
      end else begin
        unique case (cfg_i.pixel_depth)
          DEPTH_MONO:  kind_in = KIND_MONO;
          DEPTH_PAL2:  kind_in = KIND_PAL2;
          DEPTH_PAL4:  kind_in = KIND_PAL4;
          DEPTH_PAL8:  kind_in = KIND_PAL8;
          DEPTH_RGB16: kind_in = KIND_RGB16;
          DEPTH_RGB32: kind_in = KIND_RGB32;
          default:     keep_in = 1'b0;
        endcase
      end
    end
  end

  always_comb begin
    s0_valid_d = s0_valid_q;
    kind_d     = kind_q;
    pos_d      = pos_q;
    data_d     = data_q;
    if (issue) begin
      pos_d = pos_q + 3'd1;
      unique case (kind_q)
        KIND_MONO: data_d[7:0] = {data_q[6:0], 1'b0};
        KIND_PAL2: data_d[7:0] = {data_q[5:0], 2'b0};
        KIND_PAL4: data_d[7:0] = {data_q[3:0], 4'b0};
        default:   data_d[7:0] = data_q[7:0];
      endcase
      if (is_last) begin
        s0_valid_d = 1'b0;
      end
    end
    if (accept) begin
      s0_valid_d = keep_in;
      kind_d     = kind_in;
      pos_d      = 3'd0;
      data_d     = mode_i ? frame_word_i
                          : {red_level_i[15:8], green_level_i[15:8],
                             blue_level_i[15:8], palette_index_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      kind_q     <= KIND_WRITE;
      pos_q      <= 3'd0;
    end else begin
      s0_valid_q <= s0_valid_d;
      kind_q     <= kind_d;
      pos_q      <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for framebuffer_pixel_expander. Palette writes and
// frame beats are driven through the valid/stall input channel, and every
// accepted beat is expanded by a local mirror of the palette and mode
// registers into a queue of expected pixels. Each pixel taken from the output
// channel is compared with the oldest one pending. A directed part covers the
// extreme words, every depth and the ignored depths. A random part follows,
// under three idling patterns on the two channels.
// ----------------------------------------------------------------------------
module tb;
  import fbpe_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_BEATS    = 150;
  localparam int SEGMENT_BEATS   = 25;

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_FRAME   = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             last;
  } pixel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [DEPTH_W-1:0] cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               mode_i;
  logic [IDX_W-1:0]   palette_index_i;
  logic [15:0]        red_level_i;
  logic [15:0]        green_level_i;
  logic [15:0]        blue_level_i;
  logic [PIX_W-1:0]   frame_word_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [PIX_W-1:0]   pixel_value_o;
  logic               last_pixel_o;

  pixel_t             pending_pixels[$];
  logic [RGB_W-1:0]   palette_mirror[PALETTE_ENTRIES];
  logic               color_mirror;
  logic [DEPTH_W-1:0] depth_mirror;
  int                 errors;
  int                 send_idle_pct;
  int                 recv_idle_pct;

  framebuffer_pixel_expander #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .palette_index_i(palette_index_i),
    .red_level_i    (red_level_i),
    .green_level_i  (green_level_i),
    .blue_level_i   (blue_level_i),
    .frame_word_i   (frame_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_value_o  (pixel_value_o),
    .last_pixel_o   (last_pixel_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic report_mismatch(string what, logic [PIX_W-1:0] got, logic [PIX_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [PIX_W-1:0] palette_pixel(logic [IDX_W-1:0] idx);
    if (int'(idx) >= PALETTE_ENTRIES) return '0;
    return {palette_mirror[idx], 8'h00};
  endfunction

  task automatic expand_beat(logic mode, logic [IDX_W-1:0] idx, logic [15:0] red,
                             logic [15:0] green, logic [15:0] blue, logic [PIX_W-1:0] word);
    logic [15:0] rgb;
    if (mode == MODE_PALETTE) begin
      if (int'(idx) < PALETTE_ENTRIES) palette_mirror[idx] = {red[15:8], green[15:8], blue[15:8]};
      return;
    end
    if (!color_mirror || depth_mirror == DEPTH_MONO) begin
      for (int k = 0; k < 8; k++) begin
        pending_pixels.push_back(pixel_t'{{24'h0, {8{~word[7-k]}}}, k == 7});
      end
      return;
    end
    case (depth_mirror)
      DEPTH_PAL2: begin
        for (int k = 0; k < 4; k++) begin
          pending_pixels.push_back(pixel_t'{palette_pixel((word[7:0] >> (6 - 2 * k)) & 8'h03),
                                            k == 3});
        end
      end
      DEPTH_PAL4: begin
        pending_pixels.push_back(pixel_t'{palette_pixel({4'h0, word[7:4]}), 1'b0});
        pending_pixels.push_back(pixel_t'{palette_pixel({4'h0, word[3:0]}), 1'b1});
      end
      DEPTH_PAL8: begin
        pending_pixels.push_back(pixel_t'{palette_pixel(word[7:0]), 1'b1});
      end
      DEPTH_RGB16: begin
        rgb = word[15:0];
        pending_pixels.push_back(pixel_t'{{rgb[14:10], rgb[14:12], rgb[9:5], rgb[9:7],
                                           rgb[4:0], rgb[4:2], 8'h00}, 1'b1});
      end
      DEPTH_RGB32: begin
        pending_pixels.push_back(pixel_t'{{word[23:0], 8'h00}, 1'b1});
      end
      default: begin
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_beat(logic mode, logic [IDX_W-1:0] idx, logic [15:0] red,
                           logic [15:0] green, logic [15:0] blue, logic [PIX_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= mode;
    palette_index_i <= idx;
    red_level_i     <= red;
    green_level_i   <= green;
    blue_level_i    <= blue;
    frame_word_i    <= word;
    do @(posedge clk_i); while (in_stall_o);
    expand_beat(mode, idx, red, green, blue, word);
    @(negedge clk_i);
  endtask

  task automatic write_palette(logic [IDX_W-1:0] idx, logic [15:0] red, logic [15:0] green,
                               logic [15:0] blue);
    send_beat(MODE_PALETTE, idx, red, green, blue, $urandom());
  endtask

  task automatic send_frame(logic [PIX_W-1:0] word);
    send_beat(MODE_FRAME, IDX_W'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), word);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [DEPTH_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_COLOR) color_mirror = value[0];
    else depth_mirror = value;
  endtask

  task automatic set_mode(logic color, logic [DEPTH_W-1:0] depth);
    write_reg(CFG_COLOR, {{(DEPTH_W-1){1'b0}}, color});
    write_reg(CFG_DEPTH, depth);
  endtask

  task automatic test_mono;
    set_mode(1'b0, DEPTH_PAL8);
    send_frame(32'h0000_0000);
    send_frame(32'h0000_00FF);
    send_frame(32'hFFFF_FF5A);
    // color path with depth zero falls back to mono
    set_mode(1'b1, DEPTH_MONO);
    send_frame(32'hC3C3_C33C);
  endtask

  task automatic test_palette_lookup;
    write_palette(8'd0, 16'hFFFF, 16'h0000, 16'h00FF);
    write_palette(8'd1, 16'h0000, 16'hFFFF, 16'hFF00);
    write_palette(8'd2, 16'hFF00, 16'h00FF, 16'hFFFF);
    write_palette(8'd3, 16'h1234, 16'h5678, 16'h9ABC);
    write_palette(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_mode(1'b1, DEPTH_PAL2);
    send_frame(32'hFFFF_FF1B);
    set_mode(1'b1, DEPTH_PAL4);
    send_frame(32'h0000_00F0);
    set_mode(1'b1, DEPTH_PAL8);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'hFFFF_FF00);
  endtask

  task automatic test_direct_color;
    set_mode(1'b1, DEPTH_RGB16);
    send_frame(32'hFFFF_7FFF);
    send_frame(32'h0000_8000);
    send_frame(32'h1234_5A5A);
    set_mode(1'b1, DEPTH_RGB32);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h8000_0001);
  endtask

  task automatic test_ignored_depths;
    set_mode(1'b1, 3'd6);
    send_frame(32'hFFFF_FFFF);
    set_mode(1'b1, 3'd7);
    send_frame(32'h0000_0000);
    // lookup right behind the write of the same entry
    set_mode(1'b1, DEPTH_PAL8);
    write_palette(8'h80, 16'hABCD, 16'h8001, 16'h7FFE);
    send_frame(32'h0000_0080);
  endtask

  task automatic test_random(int beats);
    logic               color;
    logic [DEPTH_W-1:0] depth;
    int                 counted;
    for (int seg = 0; seg < beats / SEGMENT_BEATS; seg++) begin
      color = ($urandom_range(0, 4) != 0);
      depth = ($urandom_range(0, 9) == 0) ? DEPTH_W'($urandom_range(6, 7))
                                          : DEPTH_W'($urandom_range(0, 5));
      set_mode(color, depth);
      counted = 0;
      while (counted < SEGMENT_BEATS) begin
        if ($urandom_range(0, 3) == 0) begin
          write_palette(IDX_W'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        end else begin
          send_frame($urandom());
        end
        counted++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with nothing pending", pixel_value_o, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_value_o !== want.value) report_mismatch("pixel_value", pixel_value_o, want.value);
        if (last_pixel_o !== want.last) begin
          report_mismatch("last_pixel", PIX_W'(last_pixel_o), PIX_W'(want.last));
        end
      end
    end
  end

  initial begin
    errors          = 0;
    send_idle_pct   = 21;
    recv_idle_pct   = 81;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_COLOR;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    mode_i          = MODE_PALETTE;
    palette_index_i = '0;
    red_level_i     = '0;
    green_level_i   = '0;
    blue_level_i    = '0;
    frame_word_i    = '0;
    out_stall_i     = 1'b0;
    color_mirror    = 1'b0;
    depth_mirror    = DEPTH_PAL8;
    for (int i = 0; i < PALETTE_ENTRIES; i++) palette_mirror[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_mono();
    test_palette_lookup();
    test_direct_color();
    test_ignored_depths();
    test_random(RANDOM_BEATS);
    send_idle_pct = 81;
    recv_idle_pct = 21;
    test_random(RANDOM_BEATS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(RANDOM_BEATS);
    drain();

    if (errors == 0) begin
      $display("framebuffer_pixel_expander verification clean");
    end else begin
      $display("framebuffer_pixel_expander verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("framebuffer_pixel_expander verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fbpe_pkg.sv
rtl/fbpe_ram.sv
rtl/fbpe_unpack.sv
rtl/framebuffer_pixel_expander.sv
tb/tb.sv
